@@ design/typed_integer_alu_assert.svh @@
// Assertion macros for the typed integer ALU back end.
`ifndef TYPED_INTEGER_ALU_ASSERT_SVH
`define TYPED_INTEGER_ALU_ASSERT_SVH

// Clocked check with a synchronous reset that masks it.
`define TIA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check on the block's own clock and reset names.
`define TIA_CHECK(lbl, prop, msg) `TIA_ASSERT(lbl, clock, reset, prop, msg)

`endif

@@ design/tia_pkg.sv @@
// Package: opcodes, type codes, queue entry and helpers of the typed integer ALU.
`timescale 1ns / 1ps
package tia_pkg;

   typedef enum logic [4:0] {
      F_ADD  = 5'd0,  F_SUB  = 5'd1,  F_MUL  = 5'd2,  F_DIV  = 5'd3,
      F_MOD  = 5'd4,  F_AND  = 5'd5,  F_OR   = 5'd6,  F_XOR  = 5'd7,
      F_LAND = 5'd8,  F_LOR  = 5'd9,  F_EQ   = 5'd10, F_NEQ  = 5'd11,
      F_LT   = 5'd12, F_GT   = 5'd13, F_LTEQ = 5'd14, F_GTEQ = 5'd15,
      F_LSH  = 5'd16, F_RSH  = 5'd17, F_NOT  = 5'd18, F_LNOT = 5'd19,
      F_INC  = 5'd20, F_DEC  = 5'd21, F_NEG  = 5'd22
   } func_type;

   localparam logic [3:0] TY_I8   = 4'd0;
   localparam logic [3:0] TY_I16  = 4'd1;
   localparam logic [3:0] TY_I32  = 4'd2;
   localparam logic [3:0] TY_I64  = 4'd3;
   localparam logic [3:0] TY_U8   = 4'd4;
   localparam logic [3:0] TY_U16  = 4'd5;
   localparam logic [3:0] TY_U32  = 4'd6;
   localparam logic [3:0] TY_U64  = 4'd7;
   localparam logic [3:0] TY_BOOL = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   // How the back end handles a request.
   typedef enum logic [1:0] {
      CL_FIX    = 2'd0,
      CL_SIMPLE = 2'd1,
      CL_MUL    = 2'd2,
      CL_DIV    = 2'd3
   } cls_type;

   // One classified request; for CL_FIX, a holds the finished value.
   typedef struct packed {
      cls_type     cls;
      logic [4:0]  func;
      logic [3:0]  rtype;
      logic [1:0]  status;
      logic        sgn;
      logic [63:0] a;
      logic [63:0] b;
   } entry_type;

   function automatic logic [6:0] type_width(input logic [3:0] t);
      logic [6:0] w;
      case (t[1:0])
         2'd0: w = 7'd8;
         2'd1: w = 7'd16;
         2'd2: w = 7'd32;
         default: w = 7'd64;
      endcase
      return w;
   endfunction

   function automatic logic [63:0] type_mask(input logic [3:0] t);
      logic [63:0] m;
      case (t[1:0])
         2'd0: m = 64'h0000_0000_0000_00FF;
         2'd1: m = 64'h0000_0000_0000_FFFF;
         2'd2: m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // Mask to the type width, sign-extend when the type is signed.
   function automatic logic [63:0] extend(input logic [63:0] v, input logic [3:0] t);
      logic [63:0] r;
      logic        s;
      s = (t < TY_U8);
      case (t[1:0])
         2'd0: r = {{56{s & v[7]}}, v[7:0]};
         2'd1: r = {{48{s & v[15]}}, v[15:0]};
         2'd2: r = {{32{s & v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

@@ design/tia_front.sv @@
// Front end: type checks and classification of each request.
`timescale 1ns / 1ps
module tia_front
   import tia_pkg::*;
(
   input  logic [4:0]  func,
   input  logic [3:0]  operand_type,
   input  logic [3:0]  second_type,
   input  logic [63:0] first_value,
   input  logic [63:0] second_value,
   output entry_type   entry
);

   logic [63:0] a_ext;
   logic [63:0] b_ext;
   logic        p;
   logic        q;

   assign a_ext = extend(first_value, operand_type);
   assign b_ext = extend(second_value, operand_type);
   assign p     = first_value[0];
   assign q     = second_value[0];

   // Classify; errors, divide by zero and bool ops finish here
   always_comb begin
      entry        = '0;
      entry.cls    = CL_FIX;
      entry.func   = func;
      entry.rtype  = '0;
      entry.status = ST_BAD;
      entry.sgn    = (operand_type < TY_U8);
      if (func > F_NEG || operand_type > TY_BOOL) begin
         entry.status = ST_BAD;
      end else if (operand_type == TY_BOOL) begin
         if (func == F_LNOT) begin
            entry.a      = {63'd0, ~p};
            entry.rtype  = TY_BOOL;
            entry.status = ST_OK;
         end else if ((func == F_LAND || func == F_LOR) && second_type == TY_BOOL) begin
            entry.a      = {63'd0, (func == F_LAND) ? (p & q) : (p | q)};
            entry.rtype  = TY_BOOL;
            entry.status = ST_OK;
         end
      end else if (func >= F_NOT) begin
         entry.cls    = CL_SIMPLE;
         entry.a      = a_ext;
         entry.rtype  = operand_type;
         entry.status = ST_OK;
      end else if (func == F_LSH || func == F_RSH) begin
         if (second_type == TY_U32) begin
            entry.cls    = CL_SIMPLE;
            entry.a      = a_ext;
            entry.b      = {32'd0, second_value[31:0]};
            entry.rtype  = operand_type;
            entry.status = ST_OK;
         end
      end else if (second_type == operand_type) begin
         entry.a      = a_ext;
         entry.b      = b_ext;
         entry.rtype  = operand_type;
         entry.status = ST_OK;
         if (func == F_DIV || func == F_MOD) begin
            if ((b_ext & type_mask(operand_type)) == 64'd0) begin
               entry.a      = '0;
               entry.status = ST_DIV0;
            end else begin
               entry.cls = CL_DIV;
            end
         end else if (func == F_MUL) begin
            entry.cls = CL_MUL;
         end else begin
            entry.cls = CL_SIMPLE;
         end
      end
   end

endmodule

@@ design/tia_queue.sv @@
// Short request queue between front and back end.
`timescale 1ns / 1ps
module tia_queue
   import tia_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type rd_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign rd_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

@@ design/tia_back.sv @@
// Back end: executes requests, sequential multiply and divide, result register.
`timescale 1ns / 1ps
`include "typed_integer_alu_assert.svh"
module tia_back
   import tia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  entry_type   q_head,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_result_value,
   output logic [3:0]  rsp_result_type,
   output logic [1:0]  rsp_status
);

   typedef enum logic [1:0] {
      S_RUN  = 2'd0,
      S_MUL  = 2'd1,
      S_DIV  = 2'd2,
      S_HOLD = 2'd3
   } state_type;

   state_type    state_ff, state_in;
   logic         out_valid_ff, out_valid_in;
   logic [63:0]  out_value_ff, out_value_in;
   logic [3:0]   out_type_ff, out_type_in;
   logic [1:0]   out_status_ff, out_status_in;
   logic [63:0]  x_ff, x_in;
   logic [63:0]  y_ff, y_in;
   logic [63:0]  acc_ff, acc_in;
   logic [63:0]  rem_ff, rem_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [4:0]   op_ff, op_in;
   logic [3:0]   type_ff, type_in;
   logic         negq_ff, negq_in;
   logic         negr_ff, negr_in;

   logic         out_free;
   logic [63:0]  simple_value;
   logic [3:0]   simple_type;
   logic [63:0]  ca, cb;
   logic [63:0]  ar;
   logic [31:0]  mul_x, mul_y;
   logic [63:0]  prod;
   logic [64:0]  rem_sh;
   logic         ge;
   logic [63:0]  seq_value;
   logic         amt_wide;
   logic         neg_a, neg_b;
   logic         pop_single;
   logic         mul_last;
   logic         hold_done;

   assign out_free = ~out_valid_ff | rsp_pop;
   assign neg_a    = q_head.sgn & q_head.a[63];
   assign neg_b    = q_head.sgn & q_head.b[63];

   // Operations finished combinationally from the queue head
   always_comb begin
      ca          = q_head.sgn ? {~q_head.a[63], q_head.a[62:0]} : q_head.a;
      cb          = q_head.sgn ? {~q_head.b[63], q_head.b[62:0]} : q_head.b;
      amt_wide    = (q_head.b[31:0] >= 32'(type_width(q_head.rtype)));
      simple_type = TY_BOOL;
      ar          = '0;
      case (q_head.func)
         F_ADD:  begin ar = q_head.a + q_head.b; simple_type = q_head.rtype; end
         F_SUB:  begin ar = q_head.a - q_head.b; simple_type = q_head.rtype; end
         F_AND:  begin ar = q_head.a & q_head.b; simple_type = q_head.rtype; end
         F_OR:   begin ar = q_head.a | q_head.b; simple_type = q_head.rtype; end
         F_XOR:  begin ar = q_head.a ^ q_head.b; simple_type = q_head.rtype; end
         F_LAND: ar = {63'd0, (q_head.a != '0) && (q_head.b != '0)};
         F_LOR:  ar = {63'd0, (q_head.a != '0) || (q_head.b != '0)};
         F_EQ:   ar = {63'd0, ca == cb};
         F_NEQ:  ar = {63'd0, ca != cb};
         F_LT:   ar = {63'd0, ca < cb};
         F_GT:   ar = {63'd0, ca > cb};
         F_LTEQ: ar = {63'd0, ca <= cb};
         F_GTEQ: ar = {63'd0, ca >= cb};
         F_LSH: begin
            ar = amt_wide ? '0 : (q_head.a << q_head.b[5:0]);
            simple_type = q_head.rtype;
         end
         F_RSH: begin
            if (amt_wide) begin
               ar = {64{neg_a}};
            end else if (q_head.sgn) begin
               ar = 64'($signed(q_head.a) >>> q_head.b[5:0]);
            end else begin
               ar = q_head.a >> q_head.b[5:0];
            end
            simple_type = q_head.rtype;
         end
         F_NOT:  begin ar = ~q_head.a; simple_type = q_head.rtype; end
         F_LNOT: ar = {63'd0, q_head.a == '0};
         F_INC:  begin ar = q_head.a + 64'd1; simple_type = q_head.rtype; end
         F_DEC:  begin ar = q_head.a - 64'd1; simple_type = q_head.rtype; end
         F_NEG: begin
            ar = q_head.sgn ? (64'd0 - q_head.a) : q_head.a;
            simple_type = q_head.rtype;
         end
         default: ar = '0;
      endcase
      simple_value = (simple_type == TY_BOOL) ? ar : (ar & type_mask(q_head.rtype));
   end

   // Shared 32x32 multiplier: low-low, low-high, high-low partial products
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin mul_x = x_ff[31:0];  mul_y = y_ff[31:0];  end
         2'd1: begin mul_x = x_ff[31:0];  mul_y = y_ff[63:32]; end
         default: begin mul_x = x_ff[63:32]; mul_y = y_ff[31:0]; end
      endcase
      prod = 64'(mul_x) * 64'(mul_y);
   end

   // One restoring divide step
   assign rem_sh = {rem_ff, x_ff[63]};
   assign ge     = (rem_sh >= {1'b0, y_ff});

   // Finished multiply, divide or remainder value, signs fixed and masked
   always_comb begin
      if (op_ff == F_MUL) begin
         seq_value = acc_ff;
      end else if (op_ff == F_DIV) begin
         seq_value = negq_ff ? (64'd0 - x_ff) : x_ff;
      end else begin
         seq_value = negr_ff ? (64'd0 - rem_ff) : rem_ff;
      end
      seq_value = seq_value & type_mask(type_ff);
   end

   // Sequencer and result register
   always_comb begin
      state_in      = state_ff;
      out_valid_in  = out_valid_ff & ~rsp_pop;
      out_value_in  = out_value_ff;
      out_type_in   = out_type_ff;
      out_status_in = out_status_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      type_in       = type_ff;
      negq_in       = negq_ff;
      negr_in       = negr_ff;
      q_pop         = 1'b0;
      case (state_ff)
         S_RUN: begin
            if (!q_empty) begin
               if (q_head.cls == CL_FIX || q_head.cls == CL_SIMPLE) begin
                  if (out_free) begin
                     q_pop         = 1'b1;
                     out_valid_in  = 1'b1;
                     out_value_in  = (q_head.cls == CL_FIX) ? q_head.a : simple_value;
                     out_type_in   = (q_head.cls == CL_FIX) ? q_head.rtype : simple_type;
                     out_status_in = (q_head.cls == CL_FIX) ? q_head.status : ST_OK;
                  end
               end else begin
                  q_pop   = 1'b1;
                  op_in   = q_head.func;
                  type_in = q_head.rtype;
                  cnt_in  = '0;
                  rem_in  = '0;
                  acc_in  = '0;
                  negq_in = neg_a ^ neg_b;
                  negr_in = neg_a;
                  if (q_head.cls == CL_MUL) begin
                     x_in     = q_head.a;
                     y_in     = q_head.b;
                     state_in = S_MUL;
                  end else begin
                     x_in     = neg_a ? (64'd0 - q_head.a) : q_head.a;
                     y_in     = neg_b ? (64'd0 - q_head.b) : q_head.b;
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_MUL: begin
            if (cnt_ff[1:0] == 2'd0) begin
               acc_in = prod;
            end else begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd2) begin
               state_in = S_HOLD;
            end
         end
         S_DIV: begin
            // remainder stays below the divisor, so 64 bits hold it
            rem_in = ge ? 64'(rem_sh - {1'b0, y_ff}) : rem_sh[63:0];
            x_in   = {x_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_value_in  = seq_value;
               out_type_in   = type_ff;
               out_status_in = ST_OK;
               state_in      = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_type_ff   <= out_type_in;
      out_status_ff <= out_status_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      type_ff       <= type_in;
      negq_ff       <= negq_in;
      negr_ff       <= negr_in;
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_result_type  = out_type_ff;
   assign rsp_status       = out_status_ff;

   // Checks
   assign pop_single = q_pop & (q_head.cls == CL_FIX || q_head.cls == CL_SIMPLE);
   assign mul_last   = (state_ff == S_MUL) && (cnt_ff[1:0] == 2'd2);
   assign hold_done  = (state_ff == S_HOLD) && out_free;

   `TIA_CHECK(a_pop_only_run, q_pop |-> (state_ff == S_RUN), "queue popped while busy")
   `TIA_CHECK(a_mul_len, mul_last |=> (state_ff == S_HOLD), "multiply overran")
   `TIA_CHECK(a_simple_out, pop_single |=> out_valid_ff, "single-cycle request lost")
   `TIA_CHECK(a_hold_drains, hold_done |=> (state_ff == S_RUN && out_valid_ff), "held result lost")

endmodule

@@ design/typed_integer_alu.sv @@
// Top level of the typed integer ALU: front end, request queue, back end.
//
//   channel   | ports                                     | handshake
//   request   | req_func .. req_second_value              | push / full
//   result    | rsp_result_value, rsp_result_type, rsp_status | pop / empty
//
// A request is written into a queue slot when accepted; the back end takes it
// from the queue head, and most requests load the result register as they
// are popped, so one request per cycle flows while results are popped
// and no multiply or divide is busy. Multiply holds the back end for load,
// 3 partial products on one shared 32x32 multiplier, deliver. Divide and
// remainder hold it for load, 64 quotient bits, deliver.
// Reset clears the queue and the result register; no clearing pass.
// A stalled result holds the back end; the queue then fills and raises full.
`timescale 1ns / 1ps
module typed_integer_alu
   import tia_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [4:0]  req_func,
   input  logic [3:0]  req_operand_type,
   input  logic [3:0]  req_second_type,
   input  logic [63:0] req_first_value,
   input  logic [63:0] req_second_value,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_result_value,
   output logic [3:0]  rsp_result_type,
   output logic [1:0]  rsp_status
);

   entry_type front_entry;
   entry_type head_entry;
   logic      q_empty;
   logic      q_pop;

   tia_front u_front (
      .func         (req_func),
      .operand_type (req_operand_type),
      .second_type  (req_second_type),
      .first_value  (req_first_value),
      .second_value (req_second_value),
      .entry        (front_entry)
   );

   tia_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (front_entry),
      .full     (full),
      .pop      (q_pop),
      .empty    (q_empty),
      .rd_entry (head_entry)
   );

   tia_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (head_entry),
      .q_pop            (q_pop),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_result_value (rsp_result_value),
      .rsp_result_type  (rsp_result_type),
      .rsp_status       (rsp_status)
   );

endmodule
